### src/iff_pkg.sv
// Package for the integer field formatter: request and result item types,
// conversion codes, flag positions, character codes and the digit-to-ASCII map.
// No dependencies.
package iff_pkg;

   localparam int DIGIT_SLOTS     = 24;
   localparam int MAX_FIELD_CHARS = 64;
   localparam int MAX_PREC        = MAX_FIELD_CHARS - 2;
   localparam int VALUE_W         = 64;
   localparam int BCD_DIGITS      = 20;
   localparam int WORK_W          = BCD_DIGITS * 4;
   localparam int SLOT_W          = $clog2(DIGIT_SLOTS);
   localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);
   localparam int BIT_CNT_W       = $clog2(VALUE_W);
   localparam int PTR_PREC        = 8;

   // conversion codes
   localparam logic [2:0] CONV_SDEC = 3'd0;
   localparam logic [2:0] CONV_UDEC = 3'd1;
   localparam logic [2:0] CONV_OCT  = 3'd2;
   localparam logic [2:0] CONV_LHEX = 3'd3;
   localparam logic [2:0] CONV_UHEX = 3'd4;
   localparam logic [2:0] CONV_PTR  = 3'd5;

   // flag bit positions
   localparam int FLAG_PLUS  = 0;
   localparam int FLAG_MINUS = 1;
   localparam int FLAG_POUND = 2;
   localparam int FLAG_BLANK = 3;
   localparam int FLAG_ZERO  = 4;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  conv_type;
      logic        is_64bit;
      logic [4:0]  format_flags;
      logic [6:0]  field_width;
      logic        precision_given;
      logic [5:0]  precision;
   } iff_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } iff_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DABBLE,
      ST_EXTRACT,
      ST_LAYOUT,
      ST_BOUND,
      ST_EMIT
   } iff_state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0, d};
      end else begin
         // 'A' - 10 and 'a' - 10
         c = (upper ? 8'h37 : 8'h57) + {4'b0, d};
      end
      return c;
   endfunction

endpackage

### src/integer_field_formatter_top.sv
// Integer field formatter: turns one conversion request into printf-style text,
// one character per result item. Depends on iff_pkg.
//
//  channel | ports                               | payload
//  --------+-------------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data      | iff_req_type (value, flags ...)
//  result  | rsp_valid, rsp_stall, rsp_data      | iff_rsp_type (out_char, last_char)
//
// One item at a time. The request is captured in IDLE and set up in PREP; decimal
// conversions then run a shift-and-add-3 binary to BCD pass (DABBLE) through the
// shared shifter. Digit extraction (EXTRACT) handles up to 22 octal digits, layout
// runs through LAYOUT and BOUND, and the field is sent at one character per cycle
// while the result side does not stall (up to 64 characters).
// Reset is synchronous and clears the sequencer and the result valid; a stall
// on the result side freezes emission, the request side stays stalled until the
// last character of the field has been loaded into the output register.
module integer_field_formatter_top
   import iff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  iff_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output iff_rsp_type rsp_data
);

   iff_state_type state_ff, state_in;
   iff_req_type   req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   iff_rsp_type   rsp_data_ff, rsp_data_in;

   logic                 base16_ff, base16_in;
   logic                 dec_ff, dec_in;
   logic                 upper_ff, upper_in;
   logic                 minus_ff, minus_in;
   logic                 fzero_ff, fzero_in;
   logic [6:0]           wid_ff, wid_in;
   logic signed [7:0]    numw_ff, numw_in;
   logic [1:0]           npre_ff, npre_in;
   logic [7:0]           pre0_ff, pre0_in;
   logic [7:0]           pre1_ff, pre1_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [WORK_W-1:0]    work_ff, work_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SLOT_W:0]      nd_ff, nd_in;
   logic [CNT_W-1:0]     zeros_ff, zeros_in;
   logic [CNT_W-1:0]     body_ff, body_in;
   logic [CNT_W-1:0]     b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;

   logic [3:0]           digit_store [DIGIT_SLOTS];
   logic                 store_we;
   logic [3:0]           store_wdata;
   logic [3:0]           digit_ff;

   // setup and layout temporaries
   logic [63:0]          mag, absmag;
   logic                 neg, pg;
   logic [5:0]           prec_s;
   logic [6:0]           w_s;
   logic [WORK_W-1:0]    adj;
   logic [3:0]           nib;
   logic signed [7:0]    numw_f, nd_s, npre_s, wmn, maxw;
   logic [CNT_W-1:0]     pad, lead, trail;
   logic                 advance;
   logic [SLOT_W-1:0]    didx;
   logic [7:0]           ch;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         nd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         nd_ff        <= nd_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      base16_ff   <= base16_in;
      dec_ff      <= dec_in;
      upper_ff    <= upper_in;
      minus_ff    <= minus_in;
      fzero_ff    <= fzero_in;
      wid_ff      <= wid_in;
      numw_ff     <= numw_in;
      npre_ff     <= npre_in;
      pre0_ff     <= pre0_in;
      pre1_ff     <= pre1_in;
      bin_ff      <= bin_in;
      work_ff     <= work_in;
      bit_cnt_ff  <= bit_cnt_in;
      zeros_ff    <= zeros_in;
      body_ff     <= body_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      total_ff    <= total_in;
   end

   // fetch the digit for the next emit position, so it is registered when that position is sent
   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[nd_ff[SLOT_W-1:0]] <= store_wdata;
      end
      digit_ff <= digit_store[didx];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      base16_in    = base16_ff;
      dec_in       = dec_ff;
      upper_in     = upper_ff;
      minus_in     = minus_ff;
      fzero_in     = fzero_ff;
      wid_in       = wid_ff;
      numw_in      = numw_ff;
      npre_in      = npre_ff;
      pre0_in      = pre0_ff;
      pre1_in      = pre1_ff;
      bin_in       = bin_ff;
      work_in      = work_ff;
      bit_cnt_in   = bit_cnt_ff;
      nd_in        = nd_ff;
      zeros_in     = zeros_ff;
      body_in      = body_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      store_we     = 1'b0;
      store_wdata  = work_ff[3:0];

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // setup decode
      w_s    = (req_ff.field_width > 7'(MAX_FIELD_CHARS)) ? 7'(MAX_FIELD_CHARS)
                                                          : req_ff.field_width;
      prec_s = (req_ff.precision > 6'(MAX_PREC)) ? 6'(MAX_PREC) : req_ff.precision;
      mag    = req_ff.value;
      if (!req_ff.is_64bit) begin
         if (req_ff.conv_type == CONV_SDEC) begin
            mag = {{32{req_ff.value[31]}}, req_ff.value[31:0]};
         end else begin
            mag = {32'b0, req_ff.value[31:0]};
         end
      end
      pg = req_ff.precision_given || (req_ff.conv_type == CONV_PTR);
      if (req_ff.conv_type == CONV_PTR) begin
         prec_s = 6'(PTR_PREC);
      end
      neg    = (req_ff.conv_type == CONV_SDEC) && mag[63];
      absmag = neg ? (64'd0 - mag) : mag;

      // shift-and-add-3 correction on every BCD digit
      adj = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         nib = work_ff[4*i +: 4];
         adj[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
      end

      // layout arithmetic
      npre_s = $signed({6'b0, npre_ff});
      nd_s   = $signed({{(7-SLOT_W){1'b0}}, nd_ff});
      wmn    = $signed({1'b0, wid_ff}) - npre_s;
      numw_f = (fzero_ff && (wmn > numw_ff)) ? wmn : numw_ff;
      maxw   = (numw_f > nd_s) ? numw_f : nd_s;
      pad    = (wid_ff > body_ff) ? (wid_ff - body_ff) : '0;
      lead   = minus_ff ? '0 : pad;
      trail  = minus_ff ? pad : '0;

      // emission
      advance = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      if (pos_ff < b1_ff) begin
         ch = CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         ch = (pos_ff == b1_ff) ? pre0_ff : pre1_ff;
      end else if (pos_ff < b3_ff) begin
         ch = CH_ZERO;
      end else if (pos_ff < b4_ff) begin
         ch = digit_char(digit_ff, upper_ff);
      end else begin
         ch = CH_SPACE;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            wid_in    = w_s;
            minus_in  = req_ff.format_flags[FLAG_MINUS];
            fzero_in  = req_ff.format_flags[FLAG_ZERO] && !pg
                        && !req_ff.format_flags[FLAG_MINUS];
            base16_in = (req_ff.conv_type >= CONV_LHEX);
            dec_in    = (req_ff.conv_type == CONV_SDEC) || (req_ff.conv_type == CONV_UDEC);
            upper_in  = (req_ff.conv_type == CONV_UHEX) || (req_ff.conv_type == CONV_PTR);
            numw_in   = pg ? $signed({2'b0, prec_s}) : 8'sd1;
            npre_in   = 2'd0;
            pre0_in   = CH_ZERO;
            pre1_in   = CH_ZERO;
            if (req_ff.conv_type == CONV_SDEC) begin
               if (neg) begin
                  npre_in = 2'd1;
                  pre0_in = CH_MINUS;
               end else if (req_ff.format_flags[FLAG_PLUS]) begin
                  npre_in = 2'd1;
                  pre0_in = CH_PLUS;
               end else if (req_ff.format_flags[FLAG_BLANK]) begin
                  npre_in = 2'd1;
                  pre0_in = CH_SPACE;
               end
            end else if (req_ff.format_flags[FLAG_POUND] && (absmag != 64'd0)) begin
               case (req_ff.conv_type)
                  CONV_LHEX: begin
                     npre_in = 2'd2;
                     pre1_in = CH_LX;
                  end
                  CONV_UHEX, CONV_PTR: begin
                     npre_in = 2'd2;
                     pre1_in = CH_UX;
                  end
                  CONV_OCT: begin
                     // the leading octal zero counts toward precision
                     npre_in = 2'd1;
                     numw_in = (pg ? $signed({2'b0, prec_s}) : 8'sd1) - 8'sd1;
                  end
                  default: begin
                  end
               endcase
            end
            nd_in = '0;
            if (req_ff.conv_type > CONV_PTR) begin
               state_in = ST_IDLE;
            end else if ((req_ff.conv_type == CONV_SDEC) || (req_ff.conv_type == CONV_UDEC)) begin
               bin_in     = absmag;
               work_in    = '0;
               bit_cnt_in = '0;
               state_in   = ST_DABBLE;
            end else begin
               work_in  = WORK_W'(absmag);
               state_in = ST_EXTRACT;
            end
         end
         ST_DABBLE: begin
            work_in    = {adj[WORK_W-2:0], bin_ff[VALUE_W-1]};
            bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            if ((work_ff == '0) || (nd_ff == (SLOT_W+1)'(DIGIT_SLOTS))) begin
               state_in = ST_LAYOUT;
            end else begin
               store_we    = 1'b1;
               store_wdata = (base16_ff || dec_ff) ? work_ff[3:0] : {1'b0, work_ff[2:0]};
               work_in     = (base16_ff || dec_ff) ? (work_ff >> 4) : (work_ff >> 3);
               nd_in       = nd_ff + 1'b1;
            end
         end
         ST_LAYOUT: begin
            zeros_in = (numw_f > nd_s) ? CNT_W'(numw_f - nd_s) : '0;
            body_in  = CNT_W'(maxw) + CNT_W'(npre_ff);
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            b1_in    = lead;
            b2_in    = lead + CNT_W'(npre_ff);
            b3_in    = lead + CNT_W'(npre_ff) + zeros_ff;
            b4_in    = lead + CNT_W'(npre_ff) + zeros_ff + CNT_W'(nd_ff);
            total_in = lead + CNT_W'(npre_ff) + zeros_ff + CNT_W'(nd_ff) + trail;
            pos_in   = '0;
            // an empty field sends nothing
            if ((lead + CNT_W'(npre_ff) + zeros_ff + CNT_W'(nd_ff) + trail) == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_char  = ch;
               rsp_data_in.last_char = (pos_ff == total_ff - 1'b1);
               pos_in                = pos_ff + 1'b1;
               if (pos_ff == total_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store slot of the digit sent at the next emit position
      didx = SLOT_W'(b4_in - pos_in - 7'd1);
   end

   // the digit store never fills: at most 22 octal digits
   a_digits_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAYOUT) |-> (nd_ff < (SLOT_W+1)'(DIGIT_SLOTS)))
      else $error("digit count reached the store depth");

   a_emit_in_field: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pos_ff < total_ff))
      else $error("emit position beyond field length");

   // a pending last character with emission under way means a fresh field
   a_last_then_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_data_ff.last_char) |-> (pos_ff == '0))
      else $error("field continued past its last character");

   a_sent_field_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && (pos_ff == total_ff - 1'b1)) |=> (state_ff == ST_IDLE && rsp_data_ff.last_char))
      else $error("last character not marked or sequencer not idle");

endmodule
